// File: src/mrrc_pkg.sv
// ----------------------------------------------------------------------------
// Modbus reply checker package
// Shared codes, widths, payload structures and helper functions for the
// Modbus RTU holding-register reply checker.
// ----------------------------------------------------------------------------
package mrrc_pkg;

   // Field widths.
   localparam int ACTION_W = 2;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int SCALE_W  = 24;
   localparam int RAW_W    = 16;
   localparam int VALUE_W  = 40;
   localparam int COUNT_W  = 4;
   localparam int CRC_W    = 16;
   localparam int CSR_IDX_W = 2;

   // Fixed-point position of the scale factor.
   localparam int FACTOR_FRAC_BITS = 16;
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1 << FACTOR_FRAC_BITS);

   // Request action codes.
   localparam logic [ACTION_W-1:0] ACT_BYTE   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_GAP    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LINK   = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_LENGTH   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_MISMATCH = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STREAK_LIMIT   = 2'd2;

   // Frame constants.
   localparam logic [COUNT_W-1:0] FRAME_LEN  = 4'd9;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd15;
   localparam logic [BYTE_W-1:0]  FUNC_READ_HOLDING = 8'h03;
   localparam logic [BYTE_W-1:0]  DEC_TENTHS      = 8'd1;
   localparam logic [BYTE_W-1:0]  DEC_HUNDREDTHS  = 8'd2;
   localparam logic [BYTE_W-1:0]  STREAK_MAX      = 8'hFF;
   localparam logic [CRC_W-1:0]   CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0]   CRC_POLY = 16'hA001;

   // Division by a constant is split into a high and a low part.
   localparam int LO_W    = 20;
   localparam int HI_W    = VALUE_W - LO_W;
   localparam int DIV_W   = 7;
   localparam int X_W     = DIV_W + LO_W;
   localparam int RHI_W   = HI_W + 1;
   localparam int RLO_W   = X_W + 1;

   localparam logic [RHI_W-1:0] RECIP_HI_ONE     = RHI_W'(64'd1 << HI_W);
   localparam logic [RHI_W-1:0] RECIP_HI_TEN     = RHI_W'((64'd1 << HI_W) / 10);
   localparam logic [RHI_W-1:0] RECIP_HI_HUNDRED = RHI_W'((64'd1 << HI_W) / 100);
   localparam logic [RLO_W-1:0] RECIP_LO_ONE     = RLO_W'(64'd1 << X_W);
   localparam logic [RLO_W-1:0] RECIP_LO_TEN     = RLO_W'((64'd1 << X_W) / 10);
   localparam logic [RLO_W-1:0] RECIP_LO_HUNDRED = RLO_W'((64'd1 << X_W) / 100);

   typedef enum logic [1:0] {
      DIV_ONE,
      DIV_TEN,
      DIV_HUNDRED
   } div_sel_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic signed [RAW_W-1:0] raw;
      logic [BYTE_W-1:0]      dec;
      logic                   invalid;
      logic [BYTE_W-1:0]      streak;
   } info_type;

   typedef struct packed {
      info_type    info;
      div_sel_type div_sel;
   } judge_type;

   typedef struct packed {
      info_type             info;
      div_sel_type          div_sel;
      logic                 neg;
      logic [VALUE_W-1:0]   mag;
   } prod_type;

   // One byte step of the Modbus CRC-16, least significant bit first.
   function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_old,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc_old ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [DIV_W-1:0] divisor(input div_sel_type sel);
      logic [DIV_W-1:0] d;
      case (sel)
         DIV_TEN:     d = 7'd10;
         DIV_HUNDRED: d = 7'd100;
         default:     d = 7'd1;
      endcase
      return d;
   endfunction

   function automatic logic [RHI_W-1:0] recip_hi(input div_sel_type sel);
      logic [RHI_W-1:0] r;
      case (sel)
         DIV_TEN:     r = RECIP_HI_TEN;
         DIV_HUNDRED: r = RECIP_HI_HUNDRED;
         default:     r = RECIP_HI_ONE;
      endcase
      return r;
   endfunction

   function automatic logic [RLO_W-1:0] recip_lo(input div_sel_type sel);
      logic [RLO_W-1:0] r;
      case (sel)
         DIV_TEN:     r = RECIP_LO_TEN;
         DIV_HUNDRED: r = RECIP_LO_HUNDRED;
         default:     r = RECIP_LO_ONE;
      endcase
      return r;
   endfunction

endpackage

// File: src/mrrc_frame.sv
// ----------------------------------------------------------------------------
// Modbus reply frame tracker
// Captures the bytes of one reply, runs the CRC, judges the frame on a gap or
// link error and keeps the failure streak.
// ----------------------------------------------------------------------------
module mrrc_frame (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mrrc_pkg::ACTION_W-1:0]     req_action,
   input  logic [mrrc_pkg::BYTE_W-1:0]       req_rx_byte,
   input  logic [mrrc_pkg::BYTE_W-1:0]       device_address,
   input  logic [mrrc_pkg::BYTE_W-1:0]       streak_limit,
   output logic                              judge_valid,
   input  logic                              judge_ready,
   output mrrc_pkg::judge_type               judge
);
   import mrrc_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic [CRC_W-1:0]   crc_last2_ff, crc_last2_in;
   logic [BYTE_W-1:0]  streak_ff, streak_in;
   logic               invalid_ff, invalid_in;
   logic               judge_valid_ff, judge_valid_in;
   judge_type          judge_ff, judge_in;
   logic [BYTE_W-1:0]  cap_ff [FRAME_LEN];

   logic               accept;
   logic               cap_we;
   logic               judge_we;
   logic               mismatch;
   logic [STATUS_W-1:0] verdict;
   logic [BYTE_W-1:0]  dec_byte;

   assign req_ready   = !judge_valid_ff || judge_ready;
   assign accept      = req_valid && req_ready;
   assign judge_valid = judge_valid_ff;
   assign judge       = judge_ff;

   // The CRC check bytes arrive low byte first.
   assign mismatch = ({cap_ff[8], cap_ff[7]} != crc_last2_ff)
                  || (cap_ff[0] != device_address)
                  || (cap_ff[1] != FUNC_READ_HOLDING);
   assign dec_byte = cap_ff[6];

   always_comb begin
      count_in       = count_ff;
      crc_in         = crc_ff;
      crc_last2_in   = crc_last2_ff;
      streak_in      = streak_ff;
      invalid_in     = invalid_ff;
      cap_we         = 1'b0;
      judge_we       = 1'b0;
      verdict        = STAT_OK;
      judge_valid_in = judge_valid_ff && !judge_ready;
      if (accept) begin
         case (req_action)
            ACT_BYTE: begin
               if (count_ff < FRAME_LEN) begin
                  cap_we = 1'b1;
                  crc_in = crc_feed(crc_ff, req_rx_byte);
                  if (count_ff == FRAME_LEN - 4'd2) begin
                     crc_last2_in = crc_ff;
                  end
               end
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 4'd1;
               end
            end
            ACT_GAP: begin
               judge_we = 1'b1;
               if (count_ff != FRAME_LEN) begin
                  verdict = STAT_LENGTH;
               end else if (mismatch) begin
                  verdict = STAT_MISMATCH;
               end
            end
            ACT_LINK: begin
               judge_we = 1'b1;
               verdict  = STAT_LENGTH;
            end
            default: begin
            end
         endcase
         if (judge_we) begin
            judge_valid_in = 1'b1;
            count_in       = '0;
            crc_in         = CRC_INIT;
            crc_last2_in   = CRC_INIT;
            if (verdict == STAT_OK) begin
               streak_in  = '0;
               invalid_in = 1'b0;
            end else begin
               streak_in  = (streak_ff == STREAK_MAX) ? streak_ff : streak_ff + 8'd1;
               invalid_in = invalid_ff || (streak_in > streak_limit);
            end
         end
      end
   end

   // A failed frame carries zero reading fields, so its product is zero too.
   always_comb begin
      judge_in.info.status  = verdict;
      judge_in.info.invalid = invalid_in;
      judge_in.info.streak  = streak_in;
      judge_in.info.raw     = '0;
      judge_in.info.dec     = '0;
      judge_in.div_sel      = DIV_ONE;
      if (verdict == STAT_OK) begin
         judge_in.info.raw = {cap_ff[3], cap_ff[4]};
         judge_in.info.dec = dec_byte;
         if (dec_byte == DEC_TENTHS) begin
            judge_in.div_sel = DIV_TEN;
         end else if (dec_byte == DEC_HUNDREDTHS) begin
            judge_in.div_sel = DIV_HUNDRED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         crc_ff         <= CRC_INIT;
         crc_last2_ff   <= CRC_INIT;
         streak_ff      <= '0;
         invalid_ff     <= 1'b0;
         judge_valid_ff <= 1'b0;
      end else begin
         count_ff       <= count_in;
         crc_ff         <= crc_in;
         crc_last2_ff   <= crc_last2_in;
         streak_ff      <= streak_in;
         invalid_ff     <= invalid_in;
         judge_valid_ff <= judge_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cap_we) begin
         cap_ff[count_ff] <= req_rx_byte;
      end
      if (judge_we) begin
         judge_ff <= judge_in;
      end
   end

endmodule

// File: src/mrrc_mult.sv
// ----------------------------------------------------------------------------
// Modbus reply scale multiplier
// Multiplies the magnitude of the reading by the unsigned scale factor and
// registers the product with its sign.
// ----------------------------------------------------------------------------
module mrrc_mult (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  mrrc_pkg::judge_type             in_judge,
   input  logic [mrrc_pkg::SCALE_W-1:0]    scale_factor,
   output logic                            out_valid,
   input  logic                            out_ready,
   output mrrc_pkg::prod_type              out_prod
);
   import mrrc_pkg::*;

   logic           valid_ff, valid_in;
   prod_type       prod_ff, prod_in;
   logic [RAW_W-1:0] raw_u;
   logic [RAW_W-1:0] mag16;
   logic           load;

   assign in_ready  = !valid_ff || out_ready;
   assign load      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;

   assign raw_u = in_judge.info.raw;
   // The most negative reading has magnitude 32768, which still fits 16 bits.
   assign mag16 = raw_u[RAW_W-1] ? (~raw_u + 16'd1) : raw_u;

   always_comb begin
      valid_in        = in_ready ? in_valid : valid_ff;
      prod_in.info    = in_judge.info;
      prod_in.div_sel = in_judge.div_sel;
      prod_in.neg     = raw_u[RAW_W-1];
      prod_in.mag     = VALUE_W'(mag16) * VALUE_W'(scale_factor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// File: src/mrrc_div.sv
// ----------------------------------------------------------------------------
// Modbus reply constant divider
// Divides the product magnitude by 1, 10 or 100 in four stages, using
// reciprocal multiplication with one correction step per half, and applies
// the sign.  The last stage is the response register.
// ----------------------------------------------------------------------------
module mrrc_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  mrrc_pkg::prod_type                    in_prod,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output mrrc_pkg::info_type                    out_info,
   output logic signed [mrrc_pkg::VALUE_W-1:0]   out_value
);
   import mrrc_pkg::*;

   // Stage 1: high half times reciprocal.
   logic               s1_valid_ff;
   logic [HI_W+RHI_W-1:0] s1_hprod_ff;
   logic [HI_W-1:0]    s1_hi_ff;
   logic [LO_W-1:0]    s1_lo_ff;
   logic               s1_neg_ff;
   div_sel_type        s1_sel_ff;
   info_type           s1_info_ff;
   // Stage 2: corrected high quotient and remainder joined to the low half.
   logic               s2_valid_ff;
   logic [HI_W-1:0]    s2_qh_ff, s2_qh_in;
   logic [X_W-1:0]     s2_x_ff, s2_x_in;
   logic               s2_neg_ff;
   div_sel_type        s2_sel_ff;
   info_type           s2_info_ff;
   // Stage 3: low part times reciprocal.
   logic               s3_valid_ff;
   logic [X_W+RLO_W-1:0] s3_xprod_ff;
   logic [X_W-1:0]     s3_x_ff;
   logic [HI_W-1:0]    s3_qh_ff;
   logic               s3_neg_ff;
   div_sel_type        s3_sel_ff;
   info_type           s3_info_ff;
   // Stage 4: response register.
   logic               s4_valid_ff;
   logic signed [VALUE_W-1:0] s4_value_ff, s4_value_in;
   info_type           s4_info_ff;

   logic s1_ready, s2_ready, s3_ready, s4_ready;

   logic [HI_W-1:0]    qh_est;
   logic [HI_W-1:0]    hi_back;
   logic [HI_W-1:0]    hi_rem;
   logic [DIV_W-1:0]   d2;
   logic [X_W-1:0]     ql_est;
   logic [X_W-1:0]     ql;
   logic [X_W-1:0]     x_back;
   logic [X_W-1:0]     x_rem;
   logic [DIV_W-1:0]   d4;
   logic [VALUE_W-1:0] q_mag;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign out_valid = s4_valid_ff;
   assign out_info  = s4_info_ff;
   assign out_value = s4_value_ff;

   // High correction.
   always_comb begin
      d2      = divisor(s1_sel_ff);
      qh_est  = s1_hprod_ff[HI_W+HI_W-1:HI_W];
      hi_back = qh_est * HI_W'(d2);
      hi_rem  = s1_hi_ff - hi_back;
      s2_qh_in = qh_est;
      if (hi_rem >= HI_W'(d2)) begin
         s2_qh_in = qh_est + 20'd1;
         hi_rem   = hi_rem - HI_W'(d2);
      end
      s2_x_in = {hi_rem[DIV_W-1:0], s1_lo_ff};
   end

   // Low correction, recombination and sign.
   always_comb begin
      d4     = divisor(s3_sel_ff);
      ql_est = s3_xprod_ff[X_W+X_W-1:X_W];
      x_back = ql_est * X_W'(d4);
      x_rem  = s3_x_ff - x_back;
      ql     = (x_rem >= X_W'(d4)) ? ql_est + 27'd1 : ql_est;
      q_mag  = {s3_qh_ff, {LO_W{1'b0}}} + VALUE_W'(ql);
      s4_value_in = s3_neg_ff ? -$signed(q_mag) : $signed(q_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_hprod_ff <= (HI_W+RHI_W)'(in_prod.mag[VALUE_W-1:LO_W])
                      * (HI_W+RHI_W)'(recip_hi(in_prod.div_sel));
         s1_hi_ff    <= in_prod.mag[VALUE_W-1:LO_W];
         s1_lo_ff    <= in_prod.mag[LO_W-1:0];
         s1_neg_ff   <= in_prod.neg;
         s1_sel_ff   <= in_prod.div_sel;
         s1_info_ff  <= in_prod.info;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_qh_ff   <= s2_qh_in;
         s2_x_ff    <= s2_x_in;
         s2_neg_ff  <= s1_neg_ff;
         s2_sel_ff  <= s1_sel_ff;
         s2_info_ff <= s1_info_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_xprod_ff <= (X_W+RLO_W)'(s2_x_ff) * (X_W+RLO_W)'(recip_lo(s2_sel_ff));
         s3_x_ff     <= s2_x_ff;
         s3_qh_ff    <= s2_qh_ff;
         s3_neg_ff   <= s2_neg_ff;
         s3_sel_ff   <= s2_sel_ff;
         s3_info_ff  <= s2_info_ff;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_value_ff <= s4_value_in;
         s4_info_ff  <= s3_info_ff;
      end
   end

endmodule

// File: src/modbus_register_response_checker_unit.sv
// ----------------------------------------------------------------------------
// Modbus RTU holding-register reply checker
// Checks a nine-byte reply to a two-register read and returns the scaled
// reading with a status and a failure streak.
// ----------------------------------------------------------------------------
// The block takes one request transaction per clock cycle while req_ready is
// high: a received byte, a frame-end gap or a receive link error.  Bytes
// produce no response; a gap or a link error produces exactly one response
// transaction, which passes through the frame judgement register, the product
// register and the four stages of the constant divider before it appears on
// the response port.  Because every stage has its own valid flag, requests
// keep flowing while a finished response is waiting to be taken, until all
// stages hold work.  Configuration writes are always accepted and take effect
// on the next cycle; they should be made only while no judged frame is still
// in flight.
module modbus_register_response_checker_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [mrrc_pkg::ACTION_W-1:0]         req_action,
   input  logic [mrrc_pkg::BYTE_W-1:0]           req_rx_byte,
   // Response channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mrrc_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [mrrc_pkg::VALUE_W-1:0]   rsp_scaled_value,
   output logic signed [mrrc_pkg::RAW_W-1:0]     rsp_raw_reading,
   output logic [mrrc_pkg::BYTE_W-1:0]           rsp_decimals_code,
   output logic                                  rsp_reading_invalid,
   output logic [mrrc_pkg::BYTE_W-1:0]           rsp_failure_streak,
   // Configuration write channel.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mrrc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mrrc_pkg::SCALE_W-1:0]          csr_wdata
);
   import mrrc_pkg::*;

   // Configuration registers.
   logic [BYTE_W-1:0]  device_address_ff, device_address_in;
   logic [SCALE_W-1:0] scale_factor_ff, scale_factor_in;
   logic [BYTE_W-1:0]  streak_limit_ff, streak_limit_in;

   // Links between the three pipeline parts.
   logic      judge_valid, judge_ready;
   judge_type judge;
   logic      prod_valid, prod_ready;
   prod_type  prod;
   info_type  rsp_info;

   // The configuration port never stalls.
   assign csr_ready = 1'b1;

   // Writes to an index beyond the register list are ignored.
   always_comb begin
      device_address_in = device_address_ff;
      scale_factor_in   = scale_factor_ff;
      streak_limit_in   = streak_limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: device_address_in = csr_wdata[BYTE_W-1:0];
            CSR_SCALE_FACTOR:   scale_factor_in   = csr_wdata;
            CSR_STREAK_LIMIT:   streak_limit_in   = csr_wdata[BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= 8'd1;
         scale_factor_ff   <= SCALE_RESET;
         streak_limit_ff   <= 8'd4;
      end else begin
         device_address_ff <= device_address_in;
         scale_factor_ff   <= scale_factor_in;
         streak_limit_ff   <= streak_limit_in;
      end
   end

   // Frame capture, CRC, judgement and failure streak.
   mrrc_frame u_frame (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_rx_byte    (req_rx_byte),
      .device_address (device_address_ff),
      .streak_limit   (streak_limit_ff),
      .judge_valid    (judge_valid),
      .judge_ready    (judge_ready),
      .judge          (judge)
   );

   // Reading magnitude times scale factor.
   mrrc_mult u_mult (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (judge_valid),
      .in_ready     (judge_ready),
      .in_judge     (judge),
      .scale_factor (scale_factor_ff),
      .out_valid    (prod_valid),
      .out_ready    (prod_ready),
      .out_prod     (prod)
   );

   // Division by the decimals divisor, truncating toward zero.
   mrrc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_prod   (prod),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_info  (rsp_info),
      .out_value (rsp_scaled_value)
   );

   assign rsp_status          = rsp_info.status;
   assign rsp_raw_reading     = rsp_info.raw;
   assign rsp_decimals_code   = rsp_info.dec;
   assign rsp_reading_invalid = rsp_info.invalid;
   assign rsp_failure_streak  = rsp_info.streak;

endmodule

// File: src/mrrc_checker.sv
// ----------------------------------------------------------------------------
// Modbus reply checker port assertions
// Watches the ports of the reply checker and flags responses that break the
// rules of the status, reading and streak fields.
// ----------------------------------------------------------------------------
module mrrc_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [mrrc_pkg::STATUS_W-1:0]         rsp_status,
   input logic signed [mrrc_pkg::VALUE_W-1:0]   rsp_scaled_value,
   input logic signed [mrrc_pkg::RAW_W-1:0]     rsp_raw_reading,
   input logic [mrrc_pkg::BYTE_W-1:0]           rsp_decimals_code,
   input logic                                  rsp_reading_invalid,
   input logic [mrrc_pkg::BYTE_W-1:0]           rsp_failure_streak
);
   import mrrc_pkg::*;

   // A stalled response transaction keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scaled_value)
                                 && $stable(rsp_status))
      else $error("stalled response changed");

   // A failed frame reports no reading and a non-zero streak.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_scaled_value == '0
         && rsp_raw_reading == '0 && rsp_decimals_code == '0
         && rsp_failure_streak != '0)
      else $error("failed frame carries reading or zero streak");

   // A good frame clears the streak and the invalid flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_OK |-> !rsp_reading_invalid
         && rsp_failure_streak == '0)
      else $error("good frame left streak or invalid flag set");

   // Only the three defined status codes appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STAT_OK || rsp_status == STAT_LENGTH
         || rsp_status == STAT_MISMATCH)
      else $error("undefined response status");

   // No response is pending right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind modbus_register_response_checker_unit mrrc_checker u_mrrc_checker (.*);

// File: tb/tb_modbus_register_response_checker_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the Modbus RTU holding-register reply checker
// Feeds reply frames, frame-end gaps and link errors into the request channel,
// predicts every status, scaled reading and failure streak from a model of the
// frame rules kept inside this module, and compares each response transaction
// with the oldest prediction under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_modbus_register_response_checker_unit;
   import mrrc_pkg::*;

   // The fourth action code has no meaning; the block must swallow it.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // Register values after reset.
   localparam logic [BYTE_W-1:0] RESET_ADDRESS = 8'd1;
   localparam logic [BYTE_W-1:0] RESET_LIMIT   = 8'd4;

   // Byte 2 of a two-register reply carries the payload length in bytes.
   localparam logic [BYTE_W-1:0] REPLY_BYTE_COUNT = 8'd4;

   // The settling wait leaves room for anything still moving through the
   // pipeline before a register write.
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 300000;

   typedef struct {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] scaled;
      logic signed [RAW_W-1:0]   raw;
      logic [BYTE_W-1:0]         dec;
      logic                      invalid;
      logic [BYTE_W-1:0]         streak;
   } reply_fields_type;

   typedef logic [BYTE_W-1:0] frame_image_type [0:8];

   // ------------------------------------------------------------------------
   // Clock, reset and the ports of the block.
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [ACTION_W-1:0]   req_action  = ACT_BYTE;
   logic [BYTE_W-1:0]     req_rx_byte = '0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_scaled_value;
   logic signed [RAW_W-1:0]   rsp_raw_reading;
   logic [BYTE_W-1:0]         rsp_decimals_code;
   logic                      rsp_reading_invalid;
   logic [BYTE_W-1:0]         rsp_failure_streak;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_DEVICE_ADDRESS;
   logic [SCALE_W-1:0]    csr_wdata = '0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   modbus_register_response_checker_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_scaled_value    (rsp_scaled_value),
      .rsp_raw_reading     (rsp_raw_reading),
      .rsp_decimals_code   (rsp_decimals_code),
      .rsp_reading_invalid (rsp_reading_invalid),
      .rsp_failure_streak  (rsp_failure_streak),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Prediction state: a copy of the registers and of the frame being
   // assembled, plus the queue of replies that are owed by the block.
   // ------------------------------------------------------------------------
   logic [BYTE_W-1:0]  cfg_address = RESET_ADDRESS;
   logic [SCALE_W-1:0] cfg_scale   = SCALE_RESET;
   logic [BYTE_W-1:0]  cfg_limit   = RESET_LIMIT;

   logic [COUNT_W-1:0] frame_count = '0;
   logic [CRC_W-1:0]   crc_live    = CRC_INIT;
   logic [CRC_W-1:0]   crc_body    = CRC_INIT;   // CRC over bytes 0 to 6
   frame_image_type    frame_bytes = '{default: '0};
   logic [BYTE_W-1:0]  fail_streak = '0;
   logic               invalid_latched = 1'b0;

   reply_fields_type pending_replies [$];

   // Idle percentages for the two sides and run statistics.
   int req_idle_pct   = 0;
   int rsp_idle_pct   = 0;
   int request_count  = 0;
   int replies_checked = 0;
   int good_replies   = 0;
   int csr_writes     = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   // Bit-serial form of the Modbus CRC: each incoming bit is folded into the
   // feedback as the register shifts towards its least significant end.
   function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] octet);
      logic [CRC_W-1:0] r;
      logic             fb;
      r = acc;
      for (int k = 0; k < BYTE_W; k++) begin
         fb = r[0] ^ octet[k];
         r  = r >> 1;
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   task automatic clear_frame_state();
      frame_count = '0;
      crc_live    = CRC_INIT;
      crc_body    = CRC_INIT;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
   endtask

   // A failed frame zeroes the reading fields, bumps the saturating streak and
   // latches the invalid flag once the streak passes the programmed limit.
   task automatic log_failure(input logic [STATUS_W-1:0] code);
      reply_fields_type r;
      if (fail_streak != STREAK_MAX) begin
         fail_streak++;
      end
      if (fail_streak > cfg_limit) begin
         invalid_latched = 1'b1;
      end
      r.status  = code;
      r.scaled  = '0;
      r.raw     = '0;
      r.dec     = '0;
      r.invalid = invalid_latched;
      r.streak  = fail_streak;
      pending_replies.push_back(r);
      clear_frame_state();
   endtask

   // Advances the model by one accepted request transaction and queues the
   // reply that it owes, if any.
   task automatic predict_reply(input logic [ACTION_W-1:0] act,
                                input logic [BYTE_W-1:0] octet);
      reply_fields_type r;
      logic [CRC_W-1:0] crc_sent;
      longint           product;
      longint           scale_div;
      case (act)
         ACT_BYTE: begin
            // Bytes past the ninth are counted but neither stored nor hashed.
            if (frame_count < FRAME_LEN) begin
               if (frame_count == FRAME_LEN - 4'd2) begin
                  crc_body = crc_live;
               end
               frame_bytes[frame_count] = octet;
               crc_live = crc16_step(crc_live, octet);
            end
            if (frame_count < COUNT_MAX) begin
               frame_count++;
            end
         end
         ACT_LINK: begin
            log_failure(STAT_LENGTH);
         end
         ACT_GAP: begin
            crc_sent = {frame_bytes[8], frame_bytes[7]};
            if (frame_count != FRAME_LEN) begin
               log_failure(STAT_LENGTH);
            end else if (crc_sent != crc_body || frame_bytes[0] != cfg_address ||
                         frame_bytes[1] != FUNC_READ_HOLDING) begin
               log_failure(STAT_MISMATCH);
            end else begin
               r.raw = {frame_bytes[3], frame_bytes[4]};
               r.dec = frame_bytes[6];
               scale_div = (r.dec == DEC_TENTHS) ? 10 : (r.dec == DEC_HUNDREDTHS) ? 100 : 1;
               // Signed reading times the unsigned factor; the division
               // truncates towards zero as the block must.
               product  = longint'(r.raw) * longint'(cfg_scale);
               r.scaled = VALUE_W'(product / scale_div);
               fail_streak     = '0;
               invalid_latched = 1'b0;
               r.status  = STAT_OK;
               r.invalid = invalid_latched;
               r.streak  = fail_streak;
               pending_replies.push_back(r);
               clear_frame_state();
            end
         end
         default: begin
            // The unused code changes nothing and owes no reply.
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Driving the request channel.
   // ------------------------------------------------------------------------

   // Sends one request transaction. Valid is only ever lowered by an idle
   // cycle, so a back-to-back item never sees valid dropped and raised again
   // in the same time step.
   task automatic send_event(input logic [ACTION_W-1:0] act,
                             input logic [BYTE_W-1:0] octet);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_rx_byte <= octet;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (act != ACT_UNUSED) begin
         request_count++;
      end
      predict_reply(act, octet);
   endtask

   // Sends the first count bytes of a reply image; bytes beyond the ninth are
   // random filler. An unused action code is slipped in before byte stray_at.
   task automatic send_bytes(input frame_image_type img, input int count, input int stray_at);
      for (int i = 0; i < count; i++) begin
         if (i == stray_at) begin
            send_event(ACT_UNUSED, 8'($urandom));
         end
         send_event(ACT_BYTE, (i < 9) ? img[i] : 8'($urandom));
      end
   endtask

   function automatic frame_image_type build_reply(input logic [BYTE_W-1:0] addr,
                                                   input logic [BYTE_W-1:0] func,
                                                   input logic [RAW_W-1:0]  reading,
                                                   input logic [BYTE_W-1:0] filler,
                                                   input logic [BYTE_W-1:0] dec);
      frame_image_type  img;
      logic [CRC_W-1:0] c;
      img[0] = addr;
      img[1] = func;
      img[2] = REPLY_BYTE_COUNT;
      img[3] = reading[15:8];
      img[4] = reading[7:0];
      img[5] = filler;
      img[6] = dec;
      c = CRC_INIT;
      for (int i = 0; i < 7; i++) c = crc16_step(c, img[i]);
      img[7] = c[7:0];
      img[8] = c[15:8];
      return img;
   endfunction

   // Readings lean on the extremes of the signed range.
   function automatic logic [RAW_W-1:0] pick_reading();
      case ($urandom_range(7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] pick_decimals();
      case ($urandom_range(5))
         0, 1:    return DEC_TENTHS;
         2, 3:    return DEC_HUNDREDTHS;
         4:       return 8'd0;
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly well-formed replies with random content, the rest broken in one
   // particular way so that each check of the block is reached on its own.
   task automatic send_random_frame();
      frame_image_type img;
      int              pick;
      pick = $urandom_range(99);
      img  = build_reply(cfg_address, FUNC_READ_HOLDING, pick_reading(), 8'($urandom),
                         pick_decimals());
      if (pick < 62) begin
         send_bytes(img, 9, -1);
         send_event(ACT_GAP, 8'($urandom));
      end else if (pick < 66) begin
         send_bytes(img, 9, $urandom_range(0, 8));
         send_event(ACT_GAP, 8'($urandom));
      end else if (pick < 72) begin
         // Wrong address with a CRC that is correct for it.
         img = build_reply(cfg_address ^ 8'($urandom_range(1, 255)), FUNC_READ_HOLDING,
                           pick_reading(), 8'($urandom), pick_decimals());
         send_bytes(img, 9, -1);
         send_event(ACT_GAP, 8'($urandom));
      end else if (pick < 78) begin
         img = build_reply(cfg_address, FUNC_READ_HOLDING ^ 8'($urandom_range(1, 255)),
                           pick_reading(), 8'($urandom), pick_decimals());
         send_bytes(img, 9, -1);
         send_event(ACT_GAP, 8'($urandom));
      end else if (pick < 84) begin
         // A single flipped bit in either CRC byte.
         img[$urandom_range(7, 8)] ^= 8'(1 << $urandom_range(0, 7));
         send_bytes(img, 9, -1);
         send_event(ACT_GAP, 8'($urandom));
      end else if (pick < 89) begin
         send_bytes(img, $urandom_range(0, 8), -1);
         send_event(ACT_GAP, 8'($urandom));
      end else if (pick < 94) begin
         // Overlong frames, some far enough to saturate the byte counter.
         send_bytes(img, $urandom_range(10, 18), -1);
         send_event(ACT_GAP, 8'($urandom));
      end else if (pick < 99) begin
         send_bytes(img, $urandom_range(0, 12), -1);
         send_event(ACT_LINK, 8'($urandom));
      end else begin
         send_event(ACT_UNUSED, 8'($urandom));
      end
   endtask

   task automatic run_random_items(input int quota);
      int start;
      start = request_count;
      while (request_count - start < quota) send_random_frame();
   endtask

   // ------------------------------------------------------------------------
   // Register writes and quiescence.
   // ------------------------------------------------------------------------

   // Holds the sender back until every owed reply has come out, then lets the
   // pipeline settle so that nothing judged is still in flight.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [SCALE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_DEVICE_ADDRESS: cfg_address = value[BYTE_W-1:0];
         CSR_SCALE_FACTOR:   cfg_scale   = value;
         CSR_STREAK_LIMIT:   cfg_limit   = value[BYTE_W-1:0];
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [BYTE_W-1:0] addr,
                                 input logic [SCALE_W-1:0] scale,
                                 input logic [BYTE_W-1:0] limit);
      wait_until_idle();
      write_register(CSR_DEVICE_ADDRESS, SCALE_W'(addr));
      write_register(CSR_SCALE_FACTOR, scale);
      write_register(CSR_STREAK_LIMIT, SCALE_W'(limit));
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Reset configuration: the most negative reading in hundredths with an
   // unused code inside the frame, an empty gap, a link error, and a reply
   // that runs one byte too long.
   task automatic test_directed_cases();
      frame_image_type img;
      img = build_reply(cfg_address, FUNC_READ_HOLDING, 16'h8000, 8'hFF, DEC_HUNDREDTHS);
      send_bytes(img, 9, 5);
      send_event(ACT_GAP, 8'h00);
      send_event(ACT_GAP, 8'hFF);
      send_event(ACT_LINK, 8'hA5);
      img = build_reply(cfg_address, FUNC_READ_HOLDING, 16'h7FFF, 8'h00, DEC_TENTHS);
      send_bytes(img, 10, -1);
      send_event(ACT_GAP, 8'h5A);
   endtask

   // Random traffic under a run of settings that includes every register at
   // both ends of its range and the reset values.
   task automatic test_register_settings();
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: apply_settings(8'h00, 24'h000000, 8'h00);
            1: apply_settings(8'hFF, 24'hFFFFFF, 8'hFF);
            2: apply_settings(8'($urandom), 24'($urandom), 8'($urandom_range(0, 6)));
            3: apply_settings(RESET_ADDRESS, SCALE_RESET, RESET_LIMIT);
            4: apply_settings(8'($urandom), 24'hFFFFFF, 8'h01);
            default: apply_settings(8'($urandom), 24'($urandom), 8'($urandom));
         endcase
         run_random_items(75);
      end
   endtask

   // Drives the failure streak into saturation. With the limit one below the
   // ceiling the invalid flag must rise only on the saturating failure; a good
   // reply then clears both.
   task automatic test_streak_saturation();
      frame_image_type img;
      apply_settings(8'($urandom), 24'($urandom), 8'hFE);
      repeat (264) begin
         case ($urandom_range(7))
            0, 1, 2: send_event(ACT_LINK, 8'($urandom));
            3, 4, 5: send_event(ACT_GAP, 8'($urandom));
            6: begin
               send_event(ACT_BYTE, 8'($urandom));
               send_event(ACT_GAP, 8'($urandom));
            end
            default: begin
               send_event(ACT_BYTE, 8'($urandom));
               send_event(ACT_LINK, 8'($urandom));
            end
         endcase
      end
      img = build_reply(cfg_address, FUNC_READ_HOLDING, pick_reading(), 8'($urandom),
                        pick_decimals());
      send_bytes(img, 9, -1);
      send_event(ACT_GAP, 8'($urandom));
   endtask

   task automatic test_random_traffic(input int quota);
      apply_settings(8'($urandom), 24'($urandom), 8'($urandom_range(0, 8)));
      run_random_items(quota);
   endtask

   // ------------------------------------------------------------------------
   // Response side: random back-pressure and the comparison of every
   // response transaction with the oldest owed reply.
   // ------------------------------------------------------------------------
   task automatic check_field(input string name,
                              input logic signed [63:0] want_value,
                              input logic signed [63:0] seen_value);
      if (want_value !== seen_value) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, name, want_value, seen_value);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : reply_checker
      reply_fields_type want;
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected response transaction, status %0d, expected none",
                     $time, rsp_status);
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("scaled_value", want.scaled, rsp_scaled_value);
            check_field("raw_reading", want.raw, rsp_raw_reading);
            check_field("decimals_code", want.dec, rsp_decimals_code);
            check_field("reading_invalid", want.invalid, rsp_reading_invalid);
            check_field("failure_streak", want.streak, rsp_failure_streak);
            replies_checked++;
            if (want.status == STAT_OK) begin
               good_replies++;
            end
         end
      end
   end

   // A hung handshake on either side ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles, %0d replies still owed",
                  $time, CYCLE_LIMIT, pending_replies.size());
         $display("[modbus_register_response_checker_unit] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence of the run.
   // ------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The sender idles lightly while the receiver stalls heavily.
      req_idle_pct = 16;
      rsp_idle_pct = 84;
      test_directed_cases();
      test_register_settings();

      // The other way round: a slow sender and a nearly always ready receiver.
      req_idle_pct = 84;
      rsp_idle_pct = 16;
      test_streak_saturation();
      test_random_traffic(130);

      // Full rate on both sides.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_traffic(130);

      wait_until_idle();
      $display("Run covered %0d request transactions and %0d replies (%0d good) under %0d",
               request_count, replies_checked, good_replies, csr_writes);
      $display("register writes, with %0d field mismatches.", mismatch_count);
      if (mismatch_count == 0) begin
         $display("[modbus_register_response_checker_unit] OK");
      end else begin
         $display("[modbus_register_response_checker_unit] ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
src/mrrc_pkg.sv
src/mrrc_frame.sv
src/mrrc_mult.sv
src/mrrc_div.sv
src/modbus_register_response_checker_unit.sv
src/mrrc_checker.sv
tb/tb_modbus_register_response_checker_unit.sv
